FILE: rtl/dq_pkg.sv
// Shared types and codes for the double-ended queue.
// Holds the command and status codes, the port field widths and the
// controller/datapath interface structs. Depends on nothing.
package dq_pkg;

  // Field widths fixed by the stream interface.
  localparam int CMD_W    = 2;
  localparam int ITEM_W   = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;
  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 40;

  // Request commands.
  localparam logic [CMD_W-1:0] CMD_PUSH_HEAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_TAIL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP_HEAD  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_POP_TAIL  = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  // Datapath to controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic null_item;
    logic out_free;
  } dq_status_t;

  // Controller to datapath.
  typedef struct packed {
    logic                wr_head;
    logic                wr_tail;
    logic                rd_head;
    logic                rd_tail;
    logic                load_now;
    logic                load_mem;
    logic [STATUS_W-1:0] code;
  } dq_ctrl_t;

endpackage

FILE: rtl/dq_datapath.sv
// Datapath of the double-ended queue: ring store, head/tail positions,
// held count and the result register.
// Depends on dq_pkg.
module dq_datapath
  import dq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int ITEM_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [ITEM_W-1:0]   item,
  input  dq_ctrl_t            ctrl,
  output dq_status_t          sts,
  input  logic                m_tready,
  output logic                m_tvalid,
  output logic [M_DATA_W-1:0] m_tdata,
  output logic [STATUS_W-1:0] m_tuser
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [ITEM_WIDTH-1:0] mem [DEPTH];
  logic [ITEM_WIDTH-1:0] rd_data;

  logic [PTR_W-1:0] front_pos, back_pos;
  logic [PTR_W-1:0] front_pos_next, back_pos_next;
  logic [PTR_W-1:0] front_inc, front_dec, back_inc, back_dec;
  logic [CNT_W-1:0] held_count, held_count_next;

  logic [ITEM_WIDTH-1:0] item_w;
  logic [PTR_W-1:0]      wr_addr, rd_addr;
  logic                  mem_we, mem_re;

  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [ITEM_W-1:0]   out_popped;
  logic [OCC_W-1:0]    out_count;

  assign item_w = ITEM_WIDTH'(item);

  assign front_inc = (front_pos == PTR_W'(DEPTH - 1)) ? '0 : front_pos + 1'b1;
  assign front_dec = (front_pos == '0) ? PTR_W'(DEPTH - 1) : front_pos - 1'b1;
  assign back_inc  = (back_pos == PTR_W'(DEPTH - 1)) ? '0 : back_pos + 1'b1;
  assign back_dec  = (back_pos == '0) ? PTR_W'(DEPTH - 1) : back_pos - 1'b1;

  always_comb begin
    front_pos_next  = front_pos;
    back_pos_next   = back_pos;
    held_count_next = held_count;
    if (ctrl.wr_head) begin
      front_pos_next  = front_dec;
      held_count_next = held_count + 1'b1;
    end
    if (ctrl.wr_tail) begin
      back_pos_next   = back_inc;
      held_count_next = held_count + 1'b1;
    end
    if (ctrl.rd_head) begin
      front_pos_next  = front_inc;
      held_count_next = held_count - 1'b1;
    end
    if (ctrl.rd_tail) begin
      back_pos_next   = back_dec;
      held_count_next = held_count - 1'b1;
    end
  end

  assign mem_we  = ctrl.wr_head | ctrl.wr_tail;
  assign mem_re  = ctrl.rd_head | ctrl.rd_tail;
  assign wr_addr = ctrl.wr_head ? front_dec : back_pos;
  assign rd_addr = ctrl.rd_head ? front_pos : back_dec;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= item_w;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_pos  <= '0;
      back_pos   <= '0;
      held_count <= '0;
    end else begin
      front_pos  <= front_pos_next;
      back_pos   <= back_pos_next;
      held_count <= held_count_next;
    end
  end

  // Result register: pushes and failed requests load it at acceptance,
  // successful pops in the cycle after, once the store read has returned.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.load_now || ctrl.load_mem) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_now) begin
      out_status <= ctrl.code;
      out_popped <= '0;
      out_count  <= OCC_W'(held_count_next);
    end else if (ctrl.load_mem) begin
      out_status <= ctrl.code;
      out_popped <= ITEM_W'(rd_data);
      out_count  <= OCC_W'(held_count);
    end
  end

  assign sts.empty     = (held_count == '0);
  assign sts.full      = (held_count == CNT_W'(DEPTH));
  assign sts.null_item = (item_w == '0);
  assign sts.out_free  = ~out_valid | m_tready;

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {(M_DATA_W - ITEM_W - OCC_W)'(0), out_count, out_popped};

endmodule

FILE: rtl/dq_control.sv
// Controller of the double-ended queue: request acceptance and sequencing
// of the store accesses. Depends on dq_pkg.
module dq_control
  import dq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [CMD_W-1:0] command,
  input  dq_status_t       sts,
  output dq_ctrl_t         ctrl
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state, state_next;
  logic accept;

  assign s_tready = (state == S_IDLE) && sts.out_free;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    ctrl       = '0;
    ctrl.code  = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (command) inside
            CMD_PUSH_HEAD, CMD_PUSH_TAIL: begin
              ctrl.load_now = 1'b1;
              if (sts.null_item) begin
                ctrl.code = ST_NULL;
              end else if (sts.full) begin
                ctrl.code = ST_FULL;
              end else begin
                ctrl.wr_head = (command == CMD_PUSH_HEAD);
                ctrl.wr_tail = (command == CMD_PUSH_TAIL);
              end
            end
            default: begin
              if (sts.empty) begin
                ctrl.load_now = 1'b1;
                ctrl.code     = ST_UNDERFLOW;
              end else begin
                ctrl.rd_head = (command == CMD_POP_HEAD);
                ctrl.rd_tail = (command == CMD_POP_TAIL);
                state_next   = S_READ;
              end
            end
          endcase
        end
      end
      S_READ: begin
        ctrl.load_mem = 1'b1;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/double_ended_queue.sv
// Top level of the bounded double-ended queue.
// Depends on dq_pkg, dq_control and dq_datapath.
//
// A bounded double-ended queue of up to DEPTH item words held in a ring
// store. Each request on the slave stream carries a command in s_tuser
// (push at head, push at tail, pop from head, pop from tail) and, for
// pushes, an item word in s_tdata; only the low ITEM_WIDTH bits of the item
// are kept. Every request gives exactly one result on the master stream:
// a status in m_tuser (success, underflow, null element refused, or
// overflow when full), the popped item (zero unless a pop succeeded) and
// the number of items held after the request. An item of zero is the null
// element and is refused before the full check; refused and failed
// requests leave the queue unchanged. A push or a failed request completes
// at acceptance, so one can be accepted every cycle while results are taken;
// a successful pop holds off the next request until its result is loaded,
// as the ring store has a single registered read port and the popped word
// appears in the cycle after the read is issued. The result register lets a
// new request be accepted in the same cycle as the previous result is taken.
// The store needs no clearing after reset: a pop only reads pushed entries.
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int ITEM_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  // Request stream.
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // [31:0] item
  input  logic [CMD_W-1:0]    s_tuser,   // [1:0] command
  // Result stream.
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // [31:0] popped_item, [36:32] occupancy
  output logic [STATUS_W-1:0] m_tuser    // [1:0] status
);

  dq_status_t sts;
  dq_ctrl_t   ctrl;

  // The controller decides what each request does from the queue flags.
  dq_control u_control (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .command  (s_tuser),
    .sts      (sts),
    .ctrl     (ctrl)
  );

  // The datapath owns the store, positions, count and result register.
  dq_datapath #(
    .DEPTH      (DEPTH),
    .ITEM_WIDTH (ITEM_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .item     (s_tdata[ITEM_W-1:0]),
    .ctrl     (ctrl),
    .sts      (sts),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

FILE: rtl/dq_checker.sv
// Port-level assertions for the double-ended queue, bound to the top level.
// Depends on dq_pkg and double_ended_queue.
module dq_checker
  import dq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input logic                clk,
  input logic                rst,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata,
  input logic [STATUS_W-1:0] m_tuser
);

  logic [OCC_W-1:0] last_occ;
  logic             out_take;
  logic [OCC_W-1:0] occ;

  assign out_take = m_tvalid && m_tready;
  assign occ      = m_tdata[ITEM_W +: OCC_W];

  // Occupancy reported by the previous result.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_occ <= '0;
    end else if (out_take) begin
      last_occ <= occ;
    end
  end

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_fail_no_item: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_OK) |-> (m_tdata[ITEM_W-1:0] == '0))
    else $error("failed request returned an item");

  a_occ_step: assert property (@(posedge clk) disable iff (rst)
    out_take |-> (occ == last_occ) || (occ == last_occ + 5'd1) ||
                 (occ == last_occ - 5'd1))
    else $error("occupancy moved by more than one");

  a_fail_keeps_occ: assert property (@(posedge clk) disable iff (rst)
    out_take && (m_tuser != ST_OK) |-> (occ == last_occ))
    else $error("failed request changed occupancy");

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (DEPTH >= 32) || (int'(occ) <= DEPTH))
    else $error("occupancy above depth");

endmodule

bind double_ended_queue dq_checker #(.DEPTH(DEPTH)) u_dq_checker (.*);
